@@ rtl/e0kc_pkg.sv @@
// ---------------------------------------------------------------------------
// e0kc_pkg
// Shared widths, tap positions, generator state type and the one-bit step
// of the E0-style combiner generator.
// ---------------------------------------------------------------------------
`default_nettype none

package e0kc_pkg;

    localparam int unsigned W_ONE   = 25;
    localparam int unsigned W_TWO   = 31;
    localparam int unsigned W_THREE = 33;
    localparam int unsigned W_FOUR  = 39;
    localparam int unsigned W_CARRY = 2;
    localparam int unsigned W_BYTE  = 8;

    localparam int unsigned W_CFG_DATA  = W_FOUR;
    localparam int unsigned W_CFG_INDEX = 3;

    // Configuration register indexes
    localparam logic [W_CFG_INDEX-1:0] REG_LFSR1_SEED = 3'd0;
    localparam logic [W_CFG_INDEX-1:0] REG_LFSR2_SEED = 3'd1;
    localparam logic [W_CFG_INDEX-1:0] REG_LFSR3_SEED = 3'd2;
    localparam logic [W_CFG_INDEX-1:0] REG_LFSR4_SEED = 3'd3;
    localparam logic [W_CFG_INDEX-1:0] REG_CARRY_SEED = 3'd4;

    // Feedback taps besides the top bit
    localparam int unsigned TAP1_A = 7;
    localparam int unsigned TAP1_B = 11;
    localparam int unsigned TAP1_C = 19;
    localparam int unsigned TAP2_A = 11;
    localparam int unsigned TAP2_B = 15;
    localparam int unsigned TAP2_C = 23;
    localparam int unsigned TAP3_A = 3;
    localparam int unsigned TAP3_B = 23;
    localparam int unsigned TAP3_C = 27;
    localparam int unsigned TAP4_A = 3;
    localparam int unsigned TAP4_B = 27;
    localparam int unsigned TAP4_C = 35;

    typedef struct packed {
        logic [W_ONE-1:0]   one;
        logic [W_TWO-1:0]   two;
        logic [W_THREE-1:0] three;
        logic [W_FOUR-1:0]  four;
        logic [W_CARRY-1:0] carry;   // bit0 = s0, bit1 = s1
    } gen_state_t;

    typedef struct packed {
        gen_state_t state;
        logic       key;
    } step_result_t;

    // One keystream bit: output the bit and advance every register once.
    function automatic step_result_t gen_step(input gen_state_t s);
        step_result_t r;
        logic         t1, t2, t3, t4;
        logic         f1, f2, f3, f4;
        logic [2:0]   count;
        logic [2:0]   total;
        logic [1:0]   d;
        t1 = s.one[W_ONE-1];
        t2 = s.two[W_TWO-1];
        t3 = s.three[W_THREE-1];
        t4 = s.four[W_FOUR-1];
        count = {2'b00, t1} + {2'b00, t2} + {2'b00, t3} + {2'b00, t4};
        total = {1'b0, s.carry[1], 1'b0} + {2'b00, s.carry[0]} + count;
        d = total[2:1];
        f1 = s.one[TAP1_A] ^ s.one[TAP1_B] ^ s.one[TAP1_C] ^ t1;
        f2 = s.two[TAP2_A] ^ s.two[TAP2_B] ^ s.two[TAP2_C] ^ t2;
        f3 = s.three[TAP3_A] ^ s.three[TAP3_B] ^ s.three[TAP3_C] ^ t3;
        f4 = s.four[TAP4_A] ^ s.four[TAP4_B] ^ s.four[TAP4_C] ^ t4;
        r.key         = t1 ^ t2 ^ t3 ^ t4 ^ s.carry[0];
        r.state.one   = {s.one[W_ONE-2:0], f1};
        r.state.two   = {s.two[W_TWO-2:0], f2};
        r.state.three = {s.three[W_THREE-2:0], f3};
        r.state.four  = {s.four[W_FOUR-2:0], f4};
        r.state.carry = {d[0] ^ s.carry[1], d[1]};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/e0kc_seed_regs.sv @@
// ---------------------------------------------------------------------------
// e0kc_seed_regs
// Seed registers written through the configuration port; a restart loads
// them into the generator.
// ---------------------------------------------------------------------------
`default_nettype none

module e0kc_seed_regs
    import e0kc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [W_CFG_INDEX-1:0] cfg_index,
    input  wire logic [W_CFG_DATA-1:0]  cfg_data,
    output gen_state_t                  seeds
);

    gen_state_t seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            // Drop bits above each register's width; ignore unknown indexes.
            case (cfg_index)
                REG_LFSR1_SEED: seed_reg.one   <= cfg_data[W_ONE-1:0];
                REG_LFSR2_SEED: seed_reg.two   <= cfg_data[W_TWO-1:0];
                REG_LFSR3_SEED: seed_reg.three <= cfg_data[W_THREE-1:0];
                REG_LFSR4_SEED: seed_reg.four  <= cfg_data[W_FOUR-1:0];
                REG_CARRY_SEED: seed_reg.carry <= cfg_data[W_CARRY-1:0];
                default:        seed_reg       <= seed_reg;
            endcase
        end
    end

    assign seeds = seed_reg;

endmodule

`default_nettype wire

@@ rtl/e0kc_keystream.sv @@
// ---------------------------------------------------------------------------
// e0kc_keystream
// Eight chained generator steps: one keystream byte and the state after it.
// ---------------------------------------------------------------------------
`default_nettype none

module e0kc_keystream
    import e0kc_pkg::*;
(
    input  wire gen_state_t         cur_state,
    output gen_state_t              nxt_state,
    output logic [W_BYTE-1:0]       key_byte
);

    always_comb
    begin
        gen_state_t   s;
        step_result_t r;
        s        = cur_state;
        key_byte = '0;
        // First bit lands in the most significant position.
        for (int i = 0; i < W_BYTE; i++)
        begin
            r = gen_step(s);
            key_byte[W_BYTE-1-i] = r.key;
            s = r.state;
        end
        nxt_state = s;
    end

endmodule

`default_nettype wire

@@ rtl/e0_style_keystream_byte_cipher.sv @@
// ---------------------------------------------------------------------------
// e0_style_keystream_byte_cipher
// E0-style combiner keystream generator that XORs one keystream byte onto
// each message byte (encrypt and decrypt are the same operation).
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  -------   ---------  ------------------------------------------------------
//  s_*       in         tdata = msg_byte; tuser = restart
//  m_*       out        tdata = {key_byte, out_byte}
//  cfg_*     in         seed writes: index 0..3 LFSR seeds, 4 carry seed
//
//  One byte per cycle sustained while m_tready stays high. A request is
//  captured in the input register, then eight chained bit steps of the four
//  LFSRs and the carry combiner run combinationally into the result register
//  and the generator state; m_* is driven from the result register.
//  Reset clears seeds and generator state; without a restart the generator
//  runs from the all-zero state. A stalled result holds both stages; s_tready
//  stays high while either stage can move.
//
`default_nettype none

module e0_style_keystream_byte_cipher
    import e0kc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] msg_byte
    input  wire logic                   s_tuser,   // [0] restart

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [15:0]                 m_tdata,   // [7:0] out_byte, [15:8] key_byte

    input  wire logic                   cfg_we,
    input  wire logic [W_CFG_INDEX-1:0] cfg_index,
    input  wire logic [W_CFG_DATA-1:0]  cfg_data
);

    gen_state_t          seeds;
    gen_state_t          gen_reg;
    gen_state_t          gen_next;
    gen_state_t          start_state;

    logic                in_valid_reg;
    logic [W_BYTE-1:0]   msg_reg;
    logic                restart_reg;

    logic                out_valid_reg;
    logic [W_BYTE-1:0]   out_byte_reg;
    logic [W_BYTE-1:0]   key_byte_reg;
    logic [W_BYTE-1:0]   key_byte;

    logic                advance;
    logic                fire;
    logic                accept;

    // Seed registers from the configuration port.
    e0kc_seed_regs u_seed_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seeds     (seeds)
    );

    // Result stage moves when its register is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // A restart reloads all generator state before this byte's bits.
    assign start_state = restart_reg ? seeds : gen_reg;

    e0kc_keystream u_keystream (
        .cur_state (start_state),
        .nxt_state (gen_next),
        .key_byte  (key_byte)
    );

    // Input register: hold while the result stage is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            msg_reg     <= s_tdata[W_BYTE-1:0];
            restart_reg <= s_tuser;
        end
    end

    // Generator state advances once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                gen_reg <= gen_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= msg_reg ^ key_byte;
            key_byte_reg <= key_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {key_byte_reg, out_byte_reg};

endmodule

`default_nettype wire
